// File: src/joystick_axis_calibrator_defines.svh
// assertion macros used by the calibrator rtl
`ifndef JOYSTICK_AXIS_CALIBRATOR_DEFINES_SVH
`define JOYSTICK_AXIS_CALIBRATOR_DEFINES_SVH

// checked on every rising edge of i_clk, held off while i_rst_n is low
`define JAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define JAC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: src/jac_pkg.sv
`default_nettype none
package jac_pkg;

    localparam int AXES         = 8;
    localparam int DEVICE_TYPES = 4;
    localparam int CHANNELS     = AXES * DEVICE_TYPES;
    localparam int CH_W         = $clog2(CHANNELS);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // bit positions in the enables field
    localparam int EN_CAL = 0;
    localparam int EN_JIT = 1;

    typedef struct packed {
        logic        op;
        logic [1:0]  device;
        logic [2:0]  axis;
        logic [15:0] sample;
        logic [15:0] left_limit;
        logic [15:0] center;
        logic [15:0] right_limit;
        logic [15:0] full_range;
        logic [15:0] null_half_width;
        logic [15:0] margin;
        logic [15:0] hold_count;
        logic [1:0]  enables;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  out_device;
        logic [2:0]  out_axis;
        logic [15:0] value;
    } t_out_rsp;

    // one channel entry: settings plus anti-jitter state
    typedef struct packed {
        logic [15:0] left_limit;
        logic [15:0] center;
        logic [15:0] right_limit;
        logic [15:0] full_range;
        logic [15:0] null_half_width;
        logic [15:0] margin;
        logic [15:0] hold_count;
        logic [1:0]  enables;
        logic [15:0] held;
        logic [15:0] count;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_CAL,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// File: src/jac_if.sv
`default_nettype none
interface jac_in_if;
    logic             valid;
    logic             ready;
    jac_pkg::t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jac_out_if;
    logic              valid;
    logic              ready;
    jac_pkg::t_out_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/joystick_axis_calibrator.sv
// a sample request passes through filter, calibrate setup, multiply, 32 divider steps and
// the result register; a direct result (no scaling) skips the multiply and divider steps
// no new request is taken until a sample's result has left S_DONE for the result register,
// which waits while that register is full and not taken; a load request gives no result
// reset: synchronous active-low i_rst_n clears control state and all 32 entry valid bits,
// so every channel reads as all zero (features off) until loaded; no clearing pass
`default_nettype none
`include "joystick_axis_calibrator_defines.svh"
module joystick_axis_calibrator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    jac_in_if.sink    i_in,
    jac_out_if.source o_out
);
    import jac_pkg::*;

    // channel memory: settings plus jitter state, one synchronous read, one write
    t_entry             r_mem [CHANNELS];
    t_entry             r_rdata;
    logic [CHANNELS-1:0] r_vld;
    logic               r_rd_vld;

    logic               mem_we;
    logic [CH_W-1:0]    mem_wa;
    t_entry             mem_wd;
    logic               mem_re;

    // request side
    logic               in_acc;
    logic               in_ok;
    logic [CH_W-1:0]    in_ch;

    t_state             r_state;
    t_state             n_state;

    // per request context
    logic [1:0]         r_dev;
    logic [2:0]         r_axis;
    logic [CH_W-1:0]    r_ch;
    logic               r_ch_ok;
    logic [15:0]        r_s;

    // scaling datapath
    logic [15:0]        r_a;
    logic [15:0]        r_b;
    logic [15:0]        r_div;
    logic               r_neg;
    logic [15:0]        r_base;
    logic               r_direct;
    logic [15:0]        r_val;
    logic [31:0]        r_quo;
    logic [15:0]        r_rem;
    logic [4:0]         r_cnt;

    // result register
    t_out_rsp           r_out;
    logic               r_out_valid;

    t_entry             ent;

    // anti-jitter
    logic signed [17:0] j_v;
    logic signed [17:0] j_lo;
    logic signed [17:0] j_hi;
    logic               j_far;
    logic               j_on;
    logic [15:0]        j_s;
    t_entry             j_ent;

    // calibration setup
    logic signed [17:0] c_s;
    logic signed [17:0] c_cen;
    logic signed [17:0] c_nul;
    logic signed [17:0] c_left;
    logic signed [17:0] c_right;
    logic signed [17:0] c_rng;
    logic signed [17:0] c_lo_null;
    logic signed [17:0] c_hi_null;
    logic signed [17:0] c_sc;
    logic signed [17:0] c_w;
    logic signed [17:0] c_n;
    logic signed [17:0] c_f;
    logic signed [17:0] c_n_abs;
    logic signed [17:0] c_f_abs;
    logic               c_lower;
    logic               c_direct;
    logic [15:0]        c_val;

    // divider step
    logic [16:0]        d_t;
    logic [16:0]        d_diff;
    logic               d_ge;

    // result
    logic signed [34:0] f_sum;
    logic [15:0]        f_val;
    logic               out_free;

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    // with the current sizes every device/axis code is a real channel
    assign in_ok    = (32'(i_in.data.device) < DEVICE_TYPES) && (32'(i_in.data.axis) < AXES);
    assign in_ch    = CH_W'(CH_W'(i_in.data.device) * CH_W'(AXES)) + CH_W'(i_in.data.axis);
    assign out_free = !r_out_valid || o_out.ready;

    // entries never loaded, or channels out of range, read as all zero
    assign ent = (r_rd_vld && r_ch_ok) ? r_rdata : '0;

    // memory access control
    assign mem_re = in_acc && (i_in.data.op == OP_SAMPLE);
    always_comb begin
        mem_we = 1'b0;
        mem_wa = in_ch;
        mem_wd = j_ent;
        if (in_acc && (i_in.data.op == OP_LOAD) && in_ok) begin
            mem_we = 1'b1;
            mem_wd.left_limit      = i_in.data.left_limit;
            mem_wd.center          = i_in.data.center;
            mem_wd.right_limit     = i_in.data.right_limit;
            mem_wd.full_range      = i_in.data.full_range;
            mem_wd.null_half_width = i_in.data.null_half_width;
            mem_wd.margin          = i_in.data.margin;
            mem_wd.hold_count      = i_in.data.hold_count;
            mem_wd.enables         = i_in.data.enables;
            mem_wd.held            = '0;
            mem_wd.count           = '0;
        end else if (r_state == S_FILT && j_on) begin
            // write back the updated jitter state
            mem_we = 1'b1;
            mem_wa = r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[in_ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vld <= r_vld[in_ch];
            end
        end
    end

    // anti-jitter: hold the old position while the sample stays near it
    always_comb begin
        j_on  = ent.enables[EN_JIT];
        j_v   = signed'({2'b00, r_s});
        j_lo  = signed'({2'b00, ent.held}) - signed'({2'b00, ent.margin});
        j_hi  = signed'({2'b00, ent.held}) + signed'({2'b00, ent.margin});
        j_far = (j_v < j_lo) || (j_v > j_hi) || (ent.count >= ent.hold_count);
        j_ent = ent;
        j_s   = r_s;
        if (j_on) begin
            if (j_far) begin
                j_ent.held  = r_s;
                j_ent.count = '0;
            end else begin
                j_ent.count = ent.count + 16'd1;
                j_s         = ent.held;
            end
        end
    end

    // calibration setup: null zone, clamp, pick a side and its width
    always_comb begin
        c_s       = signed'({2'b00, r_s});
        c_cen     = signed'({2'b00, ent.center});
        c_nul     = signed'({2'b00, ent.null_half_width});
        c_left    = signed'({2'b00, ent.left_limit});
        c_right   = signed'({2'b00, ent.right_limit});
        c_rng     = signed'({2'b00, ent.full_range});
        c_lo_null = c_cen - c_nul;
        c_hi_null = c_cen + c_nul;
        c_sc      = c_s;
        if (c_sc < c_left) begin
            c_sc = c_left;
        end
        // right limit wins when the limits cross
        if (c_sc > c_right) begin
            c_sc = c_right;
        end
        c_lower = (c_sc < c_cen);
        if (c_lower) begin
            c_w = c_lo_null - c_left;
            c_n = c_sc - c_left;
            c_f = c_cen;
        end else begin
            c_w = c_right - c_hi_null;
            c_n = c_sc - c_hi_null;
            c_f = c_rng - c_cen;
        end
        c_n_abs  = c_n[17] ? -c_n : c_n;
        c_f_abs  = c_f[17] ? -c_f : c_f;
        c_direct = 1'b1;
        c_val    = ent.center;
        if (!ent.enables[EN_CAL]) begin
            c_val = r_s;
        end else if ((c_s >= c_lo_null) && (c_s <= c_hi_null)) begin
            c_val = ent.center;
        end else if (c_w <= 18'sd0) begin
            c_val = ent.center;
        end else if (c_lower && (c_n <= 18'sd0)) begin
            c_val = '0;
        end else begin
            c_direct = 1'b0;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign d_t    = {r_rem, r_quo[31]};
    assign d_ge   = (d_t >= {1'b0, r_div});
    assign d_diff = d_t - {1'b0, r_div};

    // final value, saturated to the 16-bit range
    always_comb begin
        f_sum = signed'({19'd0, r_base}) + (r_neg ? -signed'({3'd0, r_quo})
                                                 : signed'({3'd0, r_quo}));
        if (r_direct) begin
            f_val = r_val;
        end else if (f_sum < 35'sd0) begin
            f_val = '0;
        end else if (f_sum > 35'sd65535) begin
            f_val = 16'hFFFF;
        end else begin
            f_val = f_sum[15:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.data.op == OP_SAMPLE)) begin
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                n_state = S_CAL;
            end
            S_CAL: begin
                n_state = c_direct ? S_DONE : S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_dev   <= i_in.data.device;
                    r_axis  <= i_in.data.axis;
                    r_ch    <= in_ch;
                    r_ch_ok <= in_ok;
                    r_s     <= i_in.data.sample;
                end
            end
            S_FILT: begin
                r_s <= j_s;
            end
            S_CAL: begin
                r_direct <= c_direct;
                r_val    <= c_val;
                r_a      <= c_n_abs[15:0];
                r_b      <= c_f_abs[15:0];
                r_div    <= c_w[15:0];
                r_neg    <= c_n[17] ^ c_f[17];
                r_base   <= c_lower ? 16'd0 : ent.center;
            end
            S_MUL: begin
                r_quo <= 32'(r_a) * 32'(r_b);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= d_ge ? d_diff[15:0] : d_t[15:0];
                r_quo <= {r_quo[30:0], d_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            default: begin
            end
        endcase
    end

    // result register, parts the response side from the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.out_device <= r_dev;
            r_out.out_axis   <= r_axis;
            r_out.value      <= f_val;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // checks
    `JAC_ASSERT(a_div_rem, (r_state == S_DIV) |-> (r_rem < r_div), "divider remainder out of range")
    `JAC_ASSERT(a_out_src, $rose(r_out_valid) |-> ($past(r_state) == S_DONE), "result not from done")
    `JAC_ASSERT(a_smp_go, (in_acc && i_in.data.op == OP_SAMPLE) |=> (r_state == S_FILT), "sample lost")
    `JAC_ASSERT(a_load_quiet, (in_acc && i_in.data.op == OP_LOAD) |=> (r_state == S_IDLE), "load busy")
    `JAC_ASSERT_ALWAYS(a_rst_idle, (!i_rst_n) |=> (r_state == S_IDLE && !r_out_valid), "reset state")

endmodule
`default_nettype wire

// File: tb/joystick_axis_calibrator_tb.sv
`timescale 1ns / 1ps
module joystick_axis_calibrator_tb;
    import jac_pkg::*;

    // enables field values built from the package bit positions
    localparam logic [1:0] ENABLE_NONE = 2'b00;
    localparam logic [1:0] ENABLE_CAL  = 2'b01 << EN_CAL;
    localparam logic [1:0] ENABLE_JIT  = 2'b01 << EN_JIT;
    localparam logic [1:0] ENABLE_BOTH = ENABLE_CAL | ENABLE_JIT;

    // the limit leaves a wide margin over the slowest correct run
    localparam int unsigned CYCLE_LIMIT = 600_000;
    // longest sample latency given by the block, plus some slack
    localparam int TAIL_CYCLES = 48;

    logic clk;
    logic rst_n;

    jac_in_if  in_req ();
    jac_out_if out_rsp ();

    joystick_axis_calibrator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_req),
        .o_out   (out_rsp)
    );

    // shadow copy of every channel: settings plus anti-jitter state
    t_entry   chan_state [CHANNELS];
    // axis reports still owed by the block, oldest first
    t_out_rsp axis_reports_due [$];

    int          mismatches;
    int unsigned cycle_count;
    bit          idling_on;
    // long receiver hold-off, counted down by the ready process
    int          rx_hold_cycles;
    int          rx_stall_left;

    // free-running clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run guard: a hang or a lost report ends here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // linear scaling of one side of center, with clamp and dead zone
    function automatic logic [15:0] scale_axis(t_entry e, logic [15:0] raw);
        longint lft, cen, rgt, rng, nul, s, n, w, q;
        lft = longint'(e.left_limit);
        cen = longint'(e.center);
        rgt = longint'(e.right_limit);
        rng = longint'(e.full_range);
        nul = longint'(e.null_half_width);
        s   = longint'(raw);
        // dead zone around center, compared without wrap
        if (s >= cen - nul && s <= cen + nul)
            return e.center;
        // crossed limits: raise to left first, then lower to right
        if (s < lft)
            s = lft;
        if (s > rgt)
            s = rgt;
        if (s < cen) begin
            w = cen - nul - lft;
            if (w <= 0)
                return e.center;
            n = s - lft;
            if (n <= 0)
                return 16'd0;
            q = (n * cen) / w;
        end else begin
            w = rgt - (cen + nul);
            if (w <= 0)
                return e.center;
            n = s - (cen + nul);
            q = cen + (n * (rng - cen)) / w;
        end
        if (q < 0)
            return 16'd0;
        if (q > 65535)
            return 16'hFFFF;
        return q[15:0];
    endfunction

    // update the shadow channel state for one accepted request and queue its report
    function automatic void track_request(t_in_req r);
        int unsigned ch;
        int          held, marg, v;
        logic [15:0] s;
        bit          in_range;
        t_out_rsp    rsp;
        in_range = (r.device < DEVICE_TYPES) && (r.axis < AXES);
        ch       = in_range ? r.device * AXES + r.axis : 0;
        s        = r.sample;
        if (r.op == OP_LOAD) begin
            if (in_range) begin
                chan_state[ch].left_limit      = r.left_limit;
                chan_state[ch].center          = r.center;
                chan_state[ch].right_limit     = r.right_limit;
                chan_state[ch].full_range      = r.full_range;
                chan_state[ch].null_half_width = r.null_half_width;
                chan_state[ch].margin          = r.margin;
                chan_state[ch].hold_count      = r.hold_count;
                chan_state[ch].enables         = r.enables;
                chan_state[ch].held            = '0;
                chan_state[ch].count           = '0;
            end
        end else begin
            if (in_range && chan_state[ch].enables[EN_JIT]) begin
                held = int'(chan_state[ch].held);
                marg = int'(chan_state[ch].margin);
                v    = int'(s);
                // near the held position and still holding: repeat the held value
                if (v < held - marg || v > held + marg ||
                    chan_state[ch].count >= chan_state[ch].hold_count) begin
                    chan_state[ch].count = '0;
                    chan_state[ch].held  = s;
                end else begin
                    chan_state[ch].count = chan_state[ch].count + 16'd1;
                    s = chan_state[ch].held;
                end
            end
            if (in_range && chan_state[ch].enables[EN_CAL])
                s = scale_axis(chan_state[ch], s);
            rsp.out_device = r.device;
            rsp.out_axis   = r.axis;
            rsp.value      = s;
            axis_reports_due.push_back(rsp);
        end
    endfunction

    // every bit of the request random, fields refined by the caller
    function automatic t_in_req random_request();
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return t_in_req'(bits[$bits(t_in_req)-1:0]);
    endfunction

    // offer one request at the falling edge and hold it until the block takes it
    task automatic send_request(t_in_req r);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        @(negedge clk);
        if (gap > 0) begin
            in_req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_req.valid = 1'b1;
        in_req.data  = r;
        do
            @(posedge clk);
        while (in_req.ready !== 1'b1);
        track_request(r);
    endtask

    task automatic load_channel(logic [1:0] dev, logic [2:0] ax, logic [15:0] lft,
                                logic [15:0] cen, logic [15:0] rgt, logic [15:0] rng,
                                logic [15:0] nul, logic [15:0] marg, logic [15:0] hold,
                                logic [1:0] en);
        t_in_req r;
        r                 = random_request();
        r.op              = OP_LOAD;
        r.device          = dev;
        r.axis            = ax;
        r.left_limit      = lft;
        r.center          = cen;
        r.right_limit     = rgt;
        r.full_range      = rng;
        r.null_half_width = nul;
        r.margin          = marg;
        r.hold_count      = hold;
        r.enables         = en;
        send_request(r);
    endtask

    // load fields of a sample request stay random, the block must ignore them
    task automatic send_sample(logic [1:0] dev, logic [2:0] ax, logic [15:0] raw);
        t_in_req r;
        r        = random_request();
        r.op     = OP_SAMPLE;
        r.device = dev;
        r.axis   = ax;
        r.sample = raw;
        send_request(r);
    endtask

    // stop offering and wait until every owed report has come back
    task automatic wait_drained();
        @(negedge clk);
        in_req.valid = 1'b0;
        while (axis_reports_due.size() != 0)
            @(posedge clk);
    endtask

    // raw value near the held position, the dead zone edges, the limits, or anywhere
    function automatic logic [15:0] pick_axis_sample(int unsigned ch);
        int v, m, h;
        m = int'(chan_state[ch].margin);
        h = int'(chan_state[ch].null_half_width);
        case ($urandom_range(0, 4))
            0, 1: v = int'(chan_state[ch].held) + int'($urandom_range(0, 2 * m + 4)) - (m + 2);
            2: v = int'(chan_state[ch].center) + int'($urandom_range(0, 2 * h + 4)) - (h + 2);
            3: v = int'($urandom_range(chan_state[ch].left_limit, chan_state[ch].right_limit));
            default: v = int'($urandom_range(0, 16'hFFFF));
        endcase
        return 16'(v);
    endfunction

    // channels after reset: both features off, raw value comes straight back
    task automatic test_unloaded_passthrough();
        send_sample(2'd0, 3'd0, 16'h0000);
        send_sample(2'd3, 3'd7, 16'hFFFF);
        send_sample(2'd2, 3'd5, 16'h5A5A);
    endtask

    // clamp below left, dead zone, lower slope, clamp above right, upper slope
    task automatic test_calibration_sides();
        load_channel(2'd1, 3'd2, 16'd1000, 16'd30000, 16'd60000, 16'd50000,
                     16'd500, 16'd0, 16'd0, ENABLE_CAL);
        send_sample(2'd1, 3'd2, 16'd0);
        send_sample(2'd1, 3'd2, 16'd29600);
        send_sample(2'd1, 3'd2, 16'd15000);
        send_sample(2'd1, 3'd2, 16'hFFFF);
        send_sample(2'd1, 3'd2, 16'd45000);
    endtask

    // zero width on both sides, then crossed limits where right wins
    task automatic test_degenerate_limits();
        load_channel(2'd0, 3'd3, 16'd19900, 16'd20000, 16'd20100, 16'd40000,
                     16'd100, 16'd0, 16'd0, ENABLE_CAL);
        send_sample(2'd0, 3'd3, 16'd100);
        send_sample(2'd0, 3'd3, 16'd40000);
        load_channel(2'd2, 3'd1, 16'd50000, 16'd30000, 16'd10000, 16'hFFFF,
                     16'd0, 16'd0, 16'd0, ENABLE_CAL);
        send_sample(2'd2, 3'd1, 16'd5000);
        send_sample(2'd2, 3'd1, 16'd60000);
    endtask

    // near samples held until the repeat count runs out, then all-ones settings
    task automatic test_antijitter_hold();
        load_channel(2'd1, 3'd6, 16'd0, 16'd0, 16'd0, 16'd0,
                     16'd0, 16'd10, 16'd2, ENABLE_JIT);
        send_sample(2'd1, 3'd6, 16'd500);
        send_sample(2'd1, 3'd6, 16'd505);
        send_sample(2'd1, 3'd6, 16'd495);
        send_sample(2'd1, 3'd6, 16'd503);
        send_sample(2'd1, 3'd6, 16'hFFFF);
        load_channel(2'd3, 3'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, ENABLE_BOTH);
        send_sample(2'd3, 3'd3, 16'h0000);
        send_sample(2'd3, 3'd3, 16'hFFFF);
    endtask

    // mostly a load followed by a run of samples on the same channel, some noise
    task automatic test_random_traffic(int n_items, bit with_idle);
        int          sent, burst, k;
        logic [1:0]  dev;
        logic [2:0]  ax;
        logic [15:0] cen, nul, lft, rgt, rng, marg, hold;
        sent = 0;
        while (sent < n_items) begin
            dev       = 2'($urandom_range(0, DEVICE_TYPES - 1));
            ax        = 3'($urandom_range(0, AXES - 1));
            // leave some runs without any idling
            idling_on = with_idle && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 7) == 0) begin
                // noise: any op, any field
                send_request(random_request());
                sent++;
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    load_channel(dev, ax, 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 2'($urandom));
                end else begin
                    cen  = 16'($urandom_range(2000, 63000));
                    nul  = 16'($urandom_range(0, 1000));
                    lft  = 16'($urandom_range(0, cen - nul - 1));
                    rgt  = 16'($urandom_range(cen + nul + 1, 65535));
                    rng  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(cen, 65535));
                    marg = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 300));
                    hold = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                       : 16'($urandom_range(0, 10));
                    load_channel(dev, ax, lft, cen, rgt, rng, nul, marg, hold,
                                 2'($urandom_range(0, 3)));
                end
                sent++;
                burst = $urandom_range(3, 20);
                for (k = 0; k < burst; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_sample(2'($urandom), 3'($urandom), 16'($urandom));
                    else
                        send_sample(dev, ax, pick_axis_sample(dev * AXES + ax));
                    sent++;
                end
            end
        end
    endtask

    // receiver holds off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        int k;
        idling_on = 1'b0;
        load_channel(2'd2, 3'd4, 16'd100, 16'd32768, 16'd65000, 16'd60000,
                     16'd50, 16'd20, 16'd3, ENABLE_BOTH);
        rx_hold_cycles = 400;
        for (k = 0; k < 24; k++) begin
            if (k[0])
                send_sample(2'd0, 3'd1, 16'($urandom));
            else
                send_sample(2'd2, 3'd4, 16'($urandom));
        end
        // sender pause until every owed report is back
        wait_drained();
    endtask

    // receiver side: random stall bursts, plus the long hold-off when asked
    initial begin
        out_rsp.ready  = 1'b0;
        rx_hold_cycles = 0;
        rx_stall_left  = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                out_rsp.ready = 1'b0;
                rx_hold_cycles--;
            end else if (rx_stall_left > 0) begin
                out_rsp.ready = 1'b0;
                rx_stall_left--;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                out_rsp.ready = 1'b0;
                rx_stall_left = $urandom_range(1, 15) - 1;
            end else begin
                out_rsp.ready = 1'b1;
            end
        end
    end

    // report checker: each accepted report against the oldest one owed
    always @(posedge clk) begin : check_axis_reports
        t_out_rsp due;
        t_out_rsp got;
        if (rst_n && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
            got = out_rsp.data;
            if (axis_reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected axis report: device %0d axis %0d value %0d",
                             got.out_device, got.out_axis, got.value);
            end else begin
                due = axis_reports_due.pop_front();
                if (got.out_device !== due.out_device || got.out_axis !== due.out_axis ||
                    got.value !== due.value) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("axis report mismatch: expected dev %0d axis %0d value %0d",
                                 due.out_device, due.out_axis, due.value);
                        $display("                      actual   dev %0d axis %0d value %0d",
                                 got.out_device, got.out_axis, got.value);
                    end
                end
            end
        end
    end

    // test sequence
    initial begin
        mismatches   = 0;
        idling_on    = 1'b0;
        rst_n        = 1'b0;
        in_req.valid = 1'b0;
        in_req.data  = '0;
        foreach (chan_state[i])
            chan_state[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part with idling on both sides
        idling_on = 1'b1;
        test_unloaded_passthrough();
        test_calibration_sides();
        test_degenerate_limits();
        test_antijitter_hold();

        test_random_traffic(850, 1'b1);
        test_output_backpressure();

        // last stretch at full rate on both sides
        idling_on = 1'b0;
        test_random_traffic(250, 1'b0);

        wait_drained();
        // catch any stray report after the last owed one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
